// ===== src/separable_x_gradient_filter_top_defines.svh =====
// Assertion macros shared by the separable x-gradient filter RTL.
`ifndef SEPARABLE_X_GRADIENT_FILTER_TOP_DEFINES_SVH
`define SEPARABLE_X_GRADIENT_FILTER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define SXG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define SXG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SXG_ASSERT_NOW(lbl, ante, cons, msg)
`define SXG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/sxg_pkg.sv =====
// Shared constants, types and helpers for the separable x-gradient filter.
package sxg_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int IDX_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);
   localparam int DIM_W       = 11;
   localparam int PIX_W       = 8;
   localparam int SUM_W       = 10;
   localparam int GRAD_W      = 8;
   localparam int CSR_ADDR_W  = 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_WIDTH  = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_HEIGHT = CSR_ADDR_W'(1);

   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);
   localparam logic [GRAD_W-1:0] GRAD_MAX    = GRAD_W'(255);

   // One classified item handed from the front to the back
   typedef struct packed {
      logic [PIX_W-1:0] incoming;    // pixel, or zero once past the last row
      logic [IDX_W-1:0] idx;         // column, line store address
      logic             use_lower;   // row above is held in the line store
      logic             use_upper;   // row two above is inside the image
      logic             col_first;   // column zero: window restarts
      logic             emit;        // a result is due at this position
      logic             last;        // final result of the frame
   } sxg_entry_type;

   // Clamp a written dimension to 1..max
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
                                                  input logic [DIM_W-1:0] max_dim);
      logic [DIM_W-1:0] res;
      res = value;
      if (value == '0) begin
         res = DIM_W'(1);
      end else if (value > max_dim) begin
         res = max_dim;
      end
      return res;
   endfunction

endpackage

// ===== src/sxg_front.sv =====
// Front end: config registers, frame position tracking and item classification.
module sxg_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sxg_pkg::PIX_W-1:0]      req_pixel,
   input  logic                           req_func,
   input  logic                           csr_we,
   input  logic [sxg_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [sxg_pkg::DIM_W-1:0]      csr_wdata,
   input  logic                           q_full,
   output logic                           q_push,
   output sxg_pkg::sxg_entry_type         q_push_data
);

   logic [sxg_pkg::DIM_W-1:0] width_ff, width_in;
   logic [sxg_pkg::DIM_W-1:0] height_ff, height_in;
   logic [sxg_pkg::IDX_W-1:0] col_ff, col_in;
   logic [sxg_pkg::ROW_W-1:0] row_ff, row_in;

   logic                      accept;
   logic                      past_end;
   logic                      ignore;
   logic                      col_zero;
   logic                      frame_done;
   logic [sxg_pkg::DIM_W-1:0] col_next;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   assign past_end   = row_ff >= sxg_pkg::ROW_W'(height_ff);
   assign ignore     = !past_end && (req_func == sxg_pkg::FUNC_FLUSH);
   assign col_zero   = col_ff == '0;
   // last result sits at column zero of the second row past the image
   assign frame_done = col_zero &&
                       (row_ff == sxg_pkg::ROW_W'(height_ff) + sxg_pkg::ROW_W'(1));
   assign col_next   = sxg_pkg::DIM_W'(col_ff) + sxg_pkg::DIM_W'(1);

   always_comb begin
      q_push_data.incoming  = past_end ? '0 : req_pixel;
      q_push_data.idx       = col_ff;
      q_push_data.use_lower = row_ff >= sxg_pkg::ROW_W'(1);
      q_push_data.use_upper = row_ff >= sxg_pkg::ROW_W'(2);
      q_push_data.col_first = col_zero;
      q_push_data.emit      = (row_ff >= sxg_pkg::ROW_W'(2)) ||
                              ((row_ff == sxg_pkg::ROW_W'(1)) && !col_zero);
      q_push_data.last      = frame_done;
   end

   assign q_push = accept && !ignore;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_we) begin
         case (csr_addr)
            sxg_pkg::REG_IMAGE_WIDTH: begin
               width_in = sxg_pkg::clamp_dim(csr_wdata, sxg_pkg::DIM_W'(sxg_pkg::MAX_WIDTH));
            end
            sxg_pkg::REG_IMAGE_HEIGHT: begin
               height_in = sxg_pkg::clamp_dim(csr_wdata,
                                              sxg_pkg::DIM_W'(sxg_pkg::MAX_HEIGHT));
            end
            default: begin
            end
         endcase
         col_in = '0;
         row_in = '0;
      end else if (q_push) begin
         if (frame_done) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next >= width_ff) begin
            col_in = '0;
            row_in = row_ff + sxg_pkg::ROW_W'(1);
         end else begin
            col_in = col_next[sxg_pkg::IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sxg_pkg::RESET_WIDTH;
         height_ff <= sxg_pkg::RESET_HEIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

// ===== src/sxg_queue.sv =====
// Short FIFO of classified items between the front and the back.
`include "separable_x_gradient_filter_top_defines.svh"

module sxg_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sxg_pkg::sxg_entry_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   q_valid,
   output sxg_pkg::sxg_entry_type q_data
);

   sxg_pkg::sxg_entry_type slots_ff [sxg_pkg::QUEUE_DEPTH];

   logic [sxg_pkg::QPTR_W-1:0] head_ff, head_in;
   logic [sxg_pkg::QPTR_W-1:0] tail_ff, tail_in;
   logic [sxg_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full    = count_ff == sxg_pkg::QCNT_W'(sxg_pkg::QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_data  = slots_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = tail_ff + sxg_pkg::QPTR_W'(1);
      end
      if (pop) begin
         head_in = head_ff + sxg_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + sxg_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - sxg_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[tail_ff] <= push_data;
      end
   end

   `SXG_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= sxg_pkg::QCNT_W'(sxg_pkg::QUEUE_DEPTH), "queue count exceeds depth")
   `SXG_ASSERT_NOW(a_no_underflow, pop, q_valid, "queue popped while empty")
   `SXG_ASSERT_NEXT(a_push_seen, push && !pop, q_valid, "pushed item not visible")

endmodule

// ===== src/sxg_back.sv =====
// Back end: line store, vertical sum, column window, gradient clamp, output register.
`include "separable_x_gradient_filter_top_defines.svh"

module sxg_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  sxg_pkg::sxg_entry_type      q_data,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [sxg_pkg::GRAD_W-1:0]  rsp_gradient,
   output logic                        rsp_last
);

   localparam int WORD_W = 2 * sxg_pkg::PIX_W;

   // word layout: upper row in the high byte, lower row in the low byte
   logic [WORD_W-1:0] line_mem [sxg_pkg::MAX_WIDTH];

   logic                          b_valid_ff, b_valid_in;
   sxg_pkg::sxg_entry_type        b_entry_ff;
   logic [WORD_W-1:0]             rd_ff;
   logic                          fwd_ff;
   logic [WORD_W-1:0]             fwd_data_ff;
   logic [sxg_pkg::SUM_W-1:0]     win_mid_ff, win_mid_in;
   logic [sxg_pkg::SUM_W-1:0]     win_new_ff, win_new_in;
   logic                          out_valid_ff, out_valid_in;
   logic [sxg_pkg::GRAD_W-1:0]    out_grad_ff;
   logic                          out_last_ff;

   logic                          out_free;
   logic                          b_fire;
   logic [WORD_W-1:0]             cur_word;
   logic [sxg_pkg::PIX_W-1:0]     lower_rd;
   logic [sxg_pkg::PIX_W-1:0]     upper_rd;
   logic [sxg_pkg::SUM_W-1:0]     vsum;
   logic [sxg_pkg::SUM_W-1:0]     right;
   logic [sxg_pkg::SUM_W:0]       diff;
   logic [sxg_pkg::GRAD_W-1:0]    grad;
   logic                          hazard;

   assign out_free = !out_valid_ff || rsp_tready;
   assign b_fire   = b_valid_ff && (!b_entry_ff.emit || out_free);
   assign pop      = q_valid && (!b_valid_ff || b_fire);
   // w=1 puts consecutive items on the same column: pass the write straight across
   assign hazard   = b_fire && (q_data.idx == b_entry_ff.idx);

   assign cur_word = fwd_ff ? fwd_data_ff : rd_ff;
   assign lower_rd = cur_word[sxg_pkg::PIX_W-1:0];
   assign upper_rd = cur_word[WORD_W-1:sxg_pkg::PIX_W];

   always_comb begin
      vsum = sxg_pkg::SUM_W'(b_entry_ff.incoming);
      if (b_entry_ff.use_lower) begin
         vsum = vsum + sxg_pkg::SUM_W'(lower_rd);
      end
      if (b_entry_ff.use_upper) begin
         vsum = vsum + sxg_pkg::SUM_W'(upper_rd);
      end
      right = b_entry_ff.col_first ? '0 : vsum;
      diff  = {1'b0, win_mid_ff} - {1'b0, right};
      if (diff[sxg_pkg::SUM_W]) begin
         grad = '0;
      end else if (diff > (sxg_pkg::SUM_W + 1)'(sxg_pkg::GRAD_MAX)) begin
         grad = sxg_pkg::GRAD_MAX;
      end else begin
         grad = diff[sxg_pkg::GRAD_W-1:0];
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (pop) begin
         b_valid_in = 1'b1;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end
      win_mid_in = win_mid_ff;
      win_new_in = win_new_ff;
      if (b_fire) begin
         win_mid_in = b_entry_ff.col_first ? '0 : win_new_ff;
         win_new_in = vsum;
      end
      out_valid_in = out_valid_ff;
      if (b_fire && b_entry_ff.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
         win_mid_ff   <= '0;
         win_new_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         win_mid_ff   <= win_mid_in;
         win_new_ff   <= win_new_in;
         out_valid_ff <= out_valid_in;
         if (pop) begin
            fwd_ff <= hazard;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_entry_ff  <= q_data;
         fwd_data_ff <= {lower_rd, b_entry_ff.incoming};
      end
      if (b_fire && b_entry_ff.emit) begin
         out_grad_ff <= grad;
         out_last_ff <= b_entry_ff.last;
      end
   end

   // line store: registered read at pop, write when the stage retires
   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff <= line_mem[q_data.idx];
      end
      if (b_fire) begin
         line_mem[b_entry_ff.idx] <= {lower_rd, b_entry_ff.incoming};
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_gradient = out_grad_ff;
   assign rsp_last     = out_last_ff;

   `SXG_ASSERT_NOW(a_last_emits, b_valid_ff && b_entry_ff.last, b_entry_ff.emit, "frame end without result")
   `SXG_ASSERT_NEXT(a_stage_hold, b_valid_ff && !b_fire, b_valid_ff && $stable(b_entry_ff), "stalled stage changed")
   `SXG_ASSERT_NOW(a_fwd_first, b_valid_ff && fwd_ff, !b_entry_ff.col_first || b_entry_ff.idx == '0, "forward on wrong column")

endmodule

// ===== src/separable_x_gradient_filter_top.sv =====
// Top level of the separable 3x3 Prewitt x-gradient filter.
//
//   channel | direction | handshake                    | payload
//   req     | in        | req_tvalid / req_tready      | tdata pixel_value, tuser func
//   rsp     | out       | rsp_tvalid / rsp_tready      | tdata gradient, tlast frame_last
//   csr     | in        | csr_we (no wait, no readback) | csr_addr index, csr_wdata value
//
// One item per clock sustained while the output is not stalled; a result passes the queue write,
// the line store read and the output register on its way out.
// The line store is a single 1024 x 16 memory, one read and one write a cycle.
// Reset is synchronous; the line store is not cleared since reads are gated by the row count.
// A four-entry queue keeps the input side accepting while the output is stalled, until full.
module separable_x_gradient_filter_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sxg_pkg::PIX_W-1:0]       req_tdata,   // [7:0] pixel_value
   input  logic [0:0]                      req_tuser,   // [0] func
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sxg_pkg::GRAD_W-1:0]      rsp_tdata,   // [7:0] gradient
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [sxg_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [sxg_pkg::DIM_W-1:0]       csr_wdata
);

   logic                   q_full;
   logic                   q_push;
   sxg_pkg::sxg_entry_type q_push_data;
   logic                   q_pop;
   logic                   q_valid;
   sxg_pkg::sxg_entry_type q_data;

   sxg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_pixel   (req_tdata),
      .req_func    (req_tuser[0]),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   sxg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_data    (q_data)
   );

   sxg_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (q_data),
      .pop          (q_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_gradient (rsp_tdata),
      .rsp_last     (rsp_tlast)
   );

endmodule

// ===== tb/sv/separable_x_gradient_filter_top_tb.sv =====
// Self-checking testbench for the separable 3x3 x-gradient filter: predictor, scoreboard, stimulus.
module separable_x_gradient_filter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_GAP        = 18;
   localparam int LONG_STALL     = 300;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 450;

   typedef struct {
      logic [sxg_pkg::GRAD_W-1:0] gradient;
      logic                       frame_last;
   } gradient_result_type;

   // Predicts the clamped gradient stream and checks what the block returns
   class gradient_scoreboard;
      logic [sxg_pkg::PIX_W-1:0]  row_above [sxg_pkg::MAX_WIDTH];
      logic [sxg_pkg::PIX_W-1:0]  row_two_above [sxg_pkg::MAX_WIDTH];
      logic [sxg_pkg::SUM_W-1:0]  column_sums [3];
      int unsigned                cur_row;
      int unsigned                cur_col;
      int unsigned                frame_results;
      logic [sxg_pkg::DIM_W-1:0]  width_reg;
      logic [sxg_pkg::DIM_W-1:0]  height_reg;
      gradient_result_type        expected_gradients [$];
      int unsigned                mismatches;
      int unsigned                gradients_checked;
      int unsigned                frames_closed;
      int unsigned                inputs_noted;
      int unsigned                flushes_ignored;

      function new();
         foreach (row_above[i]) begin
            row_above[i]     = '0;
            row_two_above[i] = '0;
         end
         width_reg  = sxg_pkg::RESET_WIDTH;
         height_reg = sxg_pkg::RESET_HEIGHT;
         restart_frame();
      endfunction

      function void restart_frame();
         cur_row       = 0;
         cur_col       = 0;
         frame_results = 0;
         foreach (column_sums[i]) column_sums[i] = '0;
      endfunction

      function int unsigned effective_dim(logic [sxg_pkg::DIM_W-1:0] value,
                                          int unsigned limit);
         if (value == '0) return 1;
         if (32'(value) > limit) return limit;
         return 32'(value);
      endfunction

      function void write_register(logic [sxg_pkg::CSR_ADDR_W-1:0] addr,
                                   logic [sxg_pkg::DIM_W-1:0] value);
         if (addr == sxg_pkg::REG_IMAGE_WIDTH) begin
            width_reg = value;
         end else begin
            height_reg = value;
         end
         restart_frame();
      endfunction

      // One accepted input transfer; queues the gradient it releases, if any
      function void note_transfer(logic func, logic [sxg_pkg::PIX_W-1:0] pix);
         int unsigned                w;
         int unsigned                h;
         int unsigned                idx;
         logic [sxg_pkg::PIX_W-1:0]  incoming;
         logic [sxg_pkg::SUM_W-1:0]  vsum;
         logic [sxg_pkg::SUM_W-1:0]  left_sum;
         logic [sxg_pkg::SUM_W-1:0]  right_sum;
         bit                         emit;
         int                         g;
         gradient_result_type        r;
         w = effective_dim(width_reg, sxg_pkg::MAX_WIDTH);
         h = effective_dim(height_reg, sxg_pkg::MAX_HEIGHT);
         inputs_noted++;
         if (cur_row < h) begin
            // flush while pixels are still due: no effect at all
            if (func == sxg_pkg::FUNC_FLUSH) begin
               flushes_ignored++;
               return;
            end
            incoming = pix;
         end else begin
            incoming = '0;    // past the last row, anything acts as a flush
         end
         idx  = cur_col % sxg_pkg::MAX_WIDTH;
         vsum = sxg_pkg::SUM_W'(incoming);
         if (cur_row >= 1) vsum += sxg_pkg::SUM_W'(row_above[idx]);
         if (cur_row >= 2) vsum += sxg_pkg::SUM_W'(row_two_above[idx]);
         row_two_above[idx] = row_above[idx];
         row_above[idx]     = incoming;

         left_sum  = column_sums[1];
         right_sum = (cur_col == 0) ? '0 : vsum;
         emit      = (cur_row >= 2) || (cur_row == 1 && cur_col >= 1);
         if (cur_col == 0) begin
            column_sums[0] = '0;
            column_sums[1] = '0;
         end else begin
            column_sums[0] = column_sums[1];
            column_sums[1] = column_sums[2];
         end
         column_sums[2] = vsum;

         cur_col++;
         if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
         end
         if (!emit) return;

         g = int'(left_sum) - int'(right_sum);
         if (g < 0) g = 0;
         if (g > 255) g = 255;
         r.gradient = sxg_pkg::GRAD_W'(g);
         frame_results++;
         r.frame_last = (frame_results >= w * h);
         if (r.frame_last) begin
            frames_closed++;
            restart_frame();
         end
         expected_gradients.push_back(r);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         mismatches++;
         if (mismatches <= 100) begin
            $display("%0t ns: %s mismatch, got %0d expected %0d (result %0d)",
                     $time, what, got, want, gradients_checked);
         end
      endtask

      task check_gradient(logic [sxg_pkg::GRAD_W-1:0] gradient, logic frame_last);
         gradient_result_type want;
         if (expected_gradients.size() == 0) begin
            report_mismatch("unexpected transfer", 32'(gradient), 32'(0));
            return;
         end
         want = expected_gradients.pop_front();
         gradients_checked++;
         if (gradient !== want.gradient) begin
            report_mismatch("gradient", 32'(gradient), 32'(want.gradient));
         end
         if (frame_last !== want.frame_last) begin
            report_mismatch("frame_last", 32'(frame_last), 32'(want.frame_last));
         end
      endtask
   endclass

   logic                               clock;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [sxg_pkg::PIX_W-1:0]          req_tdata  = '0;
   logic [0:0]                         req_tuser  = sxg_pkg::FUNC_PIXEL;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [sxg_pkg::GRAD_W-1:0]         rsp_tdata;
   logic                               rsp_tlast;
   logic                               csr_we     = 1'b0;
   logic [sxg_pkg::CSR_ADDR_W-1:0]     csr_addr   = sxg_pkg::REG_IMAGE_WIDTH;
   logic [sxg_pkg::DIM_W-1:0]          csr_wdata  = '0;

   gradient_scoreboard     sb;
   bit                     long_stall_request;
   int unsigned            long_stalls_done;
   int unsigned            pattern_items;

   separable_x_gradient_filter_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // a little over a third of the draws give no wait, so bursts show up next to long gaps
   function automatic int pick_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic [sxg_pkg::PIX_W-1:0] pick_pixel();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return sxg_pkg::PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   // entered and left at a falling edge
   task automatic send_item(input logic func, input logic [sxg_pkg::PIX_W-1:0] pix);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= func;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_transfer(func, pix);
      @(negedge clock);
   endtask

   // pixels of a frame, with stray flushes mixed in when noisy, then the draining tail
   task automatic send_frame(input int unsigned pixels, input int unsigned tail,
                             input bit noisy);
      for (int unsigned k = 0; k < pixels; k++) begin
         if (noisy && $urandom_range(0, 9) == 0) send_item(sxg_pkg::FUNC_FLUSH, pick_pixel());
         send_item(sxg_pkg::FUNC_PIXEL, pick_pixel());
         pattern_items++;
      end
      for (int unsigned k = 0; k < tail; k++) begin
         send_item($urandom_range(0, 1) ? sxg_pkg::FUNC_FLUSH : sxg_pkg::FUNC_PIXEL,
                   pick_pixel());
         pattern_items++;
      end
   endtask

   // sender pauses until every gradient is back and the pipeline has gone quiet
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_gradients.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // only while idle; csr_we stays high across back-to-back writes
   task automatic set_dimensions(input bit do_w, input bit do_h,
                                 input logic [sxg_pkg::DIM_W-1:0] w_val,
                                 input logic [sxg_pkg::DIM_W-1:0] h_val);
      if (do_w) begin
         csr_we    <= 1'b1;
         csr_addr  <= sxg_pkg::REG_IMAGE_WIDTH;
         csr_wdata <= w_val;
         @(posedge clock);
         sb.write_register(sxg_pkg::REG_IMAGE_WIDTH, w_val);
         @(negedge clock);
      end
      if (do_h) begin
         csr_we    <= 1'b1;
         csr_addr  <= sxg_pkg::REG_IMAGE_HEIGHT;
         csr_wdata <= h_val;
         @(posedge clock);
         sb.write_register(sxg_pkg::REG_IMAGE_HEIGHT, h_val);
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin : result_sink
      int gap;
      while (reset) @(negedge clock);
      forever begin
         gap = pick_gap();
         if (long_stall_request) begin
            long_stall_request = 1'b0;
            long_stalls_done++;
            gap = LONG_STALL;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_gradient(rsp_tdata, rsp_tlast);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("watchdog: no transfer for %0d cycles, %0d gradients outstanding",
               WATCHDOG_LIMIT, sb.expected_gradients.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int unsigned w_now;
      int unsigned h_now;
      int unsigned frames;
      int unsigned cut;
      int unsigned phase;
      int unsigned mode;
      bit          broken;
      sb = new();
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // 3x3 frame: saturating and negative gradients, ignored and converted flushes
      set_dimensions(1'b1, 1'b1, sxg_pkg::DIM_W'(3), sxg_pkg::DIM_W'(3));
      send_item(sxg_pkg::FUNC_FLUSH, 8'hFF);
      send_item(sxg_pkg::FUNC_PIXEL, 8'hFF);
      send_item(sxg_pkg::FUNC_PIXEL, 8'h00);
      send_item(sxg_pkg::FUNC_PIXEL, 8'hFF);
      send_item(sxg_pkg::FUNC_PIXEL, 8'hFF);
      send_item(sxg_pkg::FUNC_PIXEL, 8'hFF);
      send_item(sxg_pkg::FUNC_FLUSH, 8'h00);
      send_item(sxg_pkg::FUNC_PIXEL, 8'h00);
      send_item(sxg_pkg::FUNC_PIXEL, 8'h00);
      send_item(sxg_pkg::FUNC_PIXEL, 8'hFF);
      send_item(sxg_pkg::FUNC_PIXEL, 8'hFF);
      send_item(sxg_pkg::FUNC_PIXEL, 8'hA5);
      send_item(sxg_pkg::FUNC_FLUSH, 8'h00);
      send_item(sxg_pkg::FUNC_PIXEL, 8'h5A);
      send_item(sxg_pkg::FUNC_FLUSH, 8'hFF);
      drain();

      // zero width acts as a single column
      set_dimensions(1'b1, 1'b1, sxg_pkg::DIM_W'(0), sxg_pkg::DIM_W'(2));
      send_item(sxg_pkg::FUNC_PIXEL, 8'hFF);
      send_item(sxg_pkg::FUNC_PIXEL, 8'h00);
      send_item(sxg_pkg::FUNC_FLUSH, 8'h00);
      send_item(sxg_pkg::FUNC_PIXEL, 8'hFF);
      drain();

      // zero height acts as a single row
      set_dimensions(1'b1, 1'b1, sxg_pkg::DIM_W'(2), sxg_pkg::DIM_W'(0));
      send_item(sxg_pkg::FUNC_PIXEL, 8'h80);
      send_item(sxg_pkg::FUNC_PIXEL, 8'h10);
      send_item(sxg_pkg::FUNC_FLUSH, 8'h00);
      send_item(sxg_pkg::FUNC_PIXEL, 8'h33);
      send_item(sxg_pkg::FUNC_FLUSH, 8'h00);
      drain();

      // random frames, mostly small, some cut short by a reconfiguration
      w_now = 1;
      h_now = 1;
      pattern_items = 0;
      phase = 0;
      while (pattern_items < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 3);
         if (phase == 0) begin
            // big enough that a long output stall backs up the input
            w_now = 16;
            h_now = 6;
            mode  = 3;
            long_stall_request = 1'b1;
         end else begin
            if (mode != 1) begin
               w_now = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                   : $urandom_range(1, 8);
            end
            if (mode != 0) h_now = $urandom_range(1, 6);
         end
         set_dimensions(mode != 1, mode != 0, sxg_pkg::DIM_W'(w_now), sxg_pkg::DIM_W'(h_now));
         frames = $urandom_range(1, 3);
         for (int unsigned f = 0; f < frames; f++) begin
            if (pattern_items >= RANDOM_ITEMS) break;
            broken = (phase != 0) && ($urandom_range(0, 7) == 0);
            if (broken) begin
               cut = $urandom_range(0, w_now * h_now - 1);
               send_frame(cut, 0, 1'b1);
               break;
            end
            send_frame(w_now * h_now, w_now + 1, 1'b1);
            if ($urandom_range(0, 5) == 0) drain();
         end
         drain();
         phase++;
      end

      $display("covered %0d input transfers (%0d flushes ignored) in %0d random phases",
               sb.inputs_noted, sb.flushes_ignored, phase);
      $display("checked %0d gradients over %0d complete frames, %0d long output stall(s)",
               sb.gradients_checked, sb.frames_closed, long_stalls_done);
      if (sb.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/sxg_pkg.sv
src/sxg_front.sv
src/sxg_queue.sv
src/sxg_back.sv
src/separable_x_gradient_filter_top.sv
tb/sv/separable_x_gradient_filter_top_tb.sv
